FILE: rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, constants and the arctangent table of the polar vector adder.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int LENGTH_BITS_DEF    = 16;
  localparam int ROTATION_STEPS_DEF = 16;

  // fraction bits of the cartesian parts
  localparam int FRAC_BITS = 8;
  // cordic gain correction, q20
  localparam int GAIN_Q20  = 636751;
  localparam int GAIN_BITS = 21;

  // field widths of the channels
  localparam int HEAD_W = ANGLE_BITS_DEF;
  localparam int LEN_W  = LENGTH_BITS_DEF;

  typedef struct packed {
    logic [HEAD_W-1:0]        first_heading;
    logic signed [LEN_W-1:0]  first_length;
    logic [HEAD_W-1:0]        second_heading;
    logic signed [LEN_W-1:0]  second_length;
  } pva_in_t;

  typedef struct packed {
    logic [HEAD_W-1:0] sum_heading;
    logic [LEN_W:0]    sum_length;
  } pva_out_t;

  // atan(2^-i) as q32 fraction of a turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      case (i)
        5'd0:  t = 32'h20000000;
        5'd1:  t = 32'h12E4051E;
        5'd2:  t = 32'h09FB385B;
        5'd3:  t = 32'h051111D4;
        5'd4:  t = 32'h028B0D43;
        5'd5:  t = 32'h0145D7E1;
        5'd6:  t = 32'h00A2F61E;
        5'd7:  t = 32'h00517C55;
        5'd8:  t = 32'h0028BE53;
        5'd9:  t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98;
        5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6;
        5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA;
        5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE;
        5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30;
        5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C;
        5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3;
        5'd23: t = 32'h00000051;
        5'd24: t = 32'h00000029;
        5'd25: t = 32'h00000014;
        5'd26: t = 32'h0000000A;
        5'd27: t = 32'h00000005;
        5'd28: t = 32'h00000003;
        5'd29: t = 32'h00000001;
        5'd30: t = 32'h00000001;
        default: t = 32'h00000000;
      endcase
      return t;
    end
  endfunction

endpackage

FILE: rtl/pva_rot_stage.sv
// ----------------------------------------------------------------------------
// pva_rot_stage
// One registered rotation-mode cordic step for both input vectors.
// ----------------------------------------------------------------------------
module pva_rot_stage #(
  parameter int STEP = 0,
  parameter int DW   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [DW-1:0] w1_i,
  input  logic signed [DW-1:0] y1_i,
  input  logic signed [32:0]   z1_i,
  input  logic signed [DW-1:0] w2_i,
  input  logic signed [DW-1:0] y2_i,
  input  logic signed [32:0]   z2_i,
  output logic                 vld_o,
  output logic signed [DW-1:0] w1_o,
  output logic signed [DW-1:0] y1_o,
  output logic signed [32:0]   z1_o,
  output logic signed [DW-1:0] w2_o,
  output logic signed [DW-1:0] y2_o,
  output logic signed [32:0]   z2_o
);

  localparam logic [32:0] ATAN = {1'b0, pva_pkg::atan_turn(5'(STEP))};

  logic                 vld_r;
  logic signed [DW-1:0] w1_r, y1_r, w2_r, y2_r;
  logic signed [32:0]   z1_r, z2_r;
  logic signed [DW-1:0] w1_nxt, y1_nxt, w2_nxt, y2_nxt;
  logic signed [32:0]   z1_nxt, z2_nxt;

  // rotate toward zero residual angle
  always_comb begin
    if (!z1_i[32]) begin
      w1_nxt = w1_i - (y1_i >>> STEP);
      y1_nxt = y1_i + (w1_i >>> STEP);
      z1_nxt = z1_i - $signed(ATAN);
    end else begin
      w1_nxt = w1_i + (y1_i >>> STEP);
      y1_nxt = y1_i - (w1_i >>> STEP);
      z1_nxt = z1_i + $signed(ATAN);
    end
    if (!z2_i[32]) begin
      w2_nxt = w2_i - (y2_i >>> STEP);
      y2_nxt = y2_i + (w2_i >>> STEP);
      z2_nxt = z2_i - $signed(ATAN);
    end else begin
      w2_nxt = w2_i + (y2_i >>> STEP);
      y2_nxt = y2_i - (w2_i >>> STEP);
      z2_nxt = z2_i + $signed(ATAN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= w1_nxt;
      y1_r <= y1_nxt;
      z1_r <= z1_nxt;
      w2_r <= w2_nxt;
      y2_r <= y2_nxt;
      z2_r <= z2_nxt;
    end
  end

  assign vld_o = vld_r;
  assign w1_o  = w1_r;
  assign y1_o  = y1_r;
  assign z1_o  = z1_r;
  assign w2_o  = w2_r;
  assign y2_o  = y2_r;
  assign z2_o  = z2_r;

endmodule

FILE: rtl/pva_vec_stage.sv
// ----------------------------------------------------------------------------
// pva_vec_stage
// One registered vectoring-mode cordic step on the summed vector.
// ----------------------------------------------------------------------------
module pva_vec_stage #(
  parameter int STEP = 0,
  parameter int DW   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic                 zero_i,
  input  logic signed [DW-1:0] u_i,
  input  logic signed [DW-1:0] x_i,
  input  logic [31:0]          z_i,
  output logic                 vld_o,
  output logic                 zero_o,
  output logic signed [DW-1:0] u_o,
  output logic signed [DW-1:0] x_o,
  output logic [31:0]          z_o
);

  localparam logic [31:0] ATAN = pva_pkg::atan_turn(5'(STEP));

  logic                 vld_r, zero_r;
  logic signed [DW-1:0] u_r, x_r, u_nxt, x_nxt;
  logic [31:0]          z_r, z_nxt;

  // drive the cross part toward zero
  always_comb begin
    if (!x_i[DW-1] && (x_i != '0)) begin
      u_nxt = u_i + (x_i >>> STEP);
      x_nxt = x_i - (u_i >>> STEP);
      z_nxt = z_i + ATAN;
    end else begin
      u_nxt = u_i - (x_i >>> STEP);
      x_nxt = x_i + (u_i >>> STEP);
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= zero_i;
      u_r    <= u_nxt;
      x_r    <= x_nxt;
      z_r    <= z_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign zero_o = zero_r;
  assign u_o    = u_r;
  assign x_o    = x_r;
  assign z_o    = z_r;

endmodule

FILE: rtl/polar_vector_add.sv
// ----------------------------------------------------------------------------
// polar_vector_add
// Sum of two polar vectors through a rotation and a vectoring cordic pipeline.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  input   | in_valid, in_stall, in_data   | pva_in_t  (two headings, lengths)
//  result  | out_valid, out_stall, out_data| pva_out_t (heading, magnitude)
//
//  one request per cycle is taken while the pipe is not stalled
//  the pipeline is one chain of stages (input and gain multiply, fold,
//  rotation steps, sum, vectoring steps, gain and round, output register)
//  a stall on the result side freezes every stage and raises in_stall only
//  when the output register holds a result, so empty slots still move
//  synchronous active-low reset clears only the valid bits
// ----------------------------------------------------------------------------
module polar_vector_add #(
  parameter int ROTATION_STEPS = pva_pkg::ROTATION_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pva_pkg::pva_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pva_pkg::pva_out_t out_data
);

  // field widths follow the payload types
  localparam int ANGLE_BITS  = pva_pkg::HEAD_W;
  localparam int LENGTH_BITS = pva_pkg::LEN_W;
  localparam int FB   = pva_pkg::FRAC_BITS;
  localparam int GB   = pva_pkg::GAIN_BITS;
  // parts after gain scaling, plus growth room for rotation and sum
  localparam int DW   = LENGTH_BITS + FB + 4;
  localparam int PW   = LENGTH_BITS + GB + 1;
  localparam int MW   = DW + GB + 1;
  localparam int SH   = 32 - ANGLE_BITS;
  localparam logic signed [GB-1:0] GAIN = GB'(pva_pkg::GAIN_Q20);

  // whole pipe advances unless a held result is stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: register input, gain multiply
  logic                 s0_vld_r;
  logic signed [PW-1:0] s0_p1_r, s0_p2_r;
  logic [31:0]          s0_z1_r, s0_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_p1_r <= PW'($signed(in_data.first_length[LENGTH_BITS-1:0]) * GAIN);
      s0_p2_r <= PW'($signed(in_data.second_length[LENGTH_BITS-1:0]) * GAIN);
      s0_z1_r <= {in_data.first_heading[ANGLE_BITS-1:0], SH'(0)};
      s0_z2_r <= {in_data.second_heading[ANGLE_BITS-1:0], SH'(0)};
    end
  end

  // stage 1: scale, fold into right half plane
  logic signed [DW-1:0] r_w1 [ROTATION_STEPS+1];
  logic signed [DW-1:0] r_y1 [ROTATION_STEPS+1];
  logic signed [32:0]   r_z1 [ROTATION_STEPS+1];
  logic signed [DW-1:0] r_w2 [ROTATION_STEPS+1];
  logic signed [DW-1:0] r_y2 [ROTATION_STEPS+1];
  logic signed [32:0]   r_z2 [ROTATION_STEPS+1];
  logic                 r_vld [ROTATION_STEPS+1];

  logic                 s1_vld_r;
  logic signed [DW-1:0] s1_w1_r, s1_w2_r;
  logic signed [32:0]   s1_z1_r, s1_z2_r;
  logic signed [DW-1:0] s1_w1_nxt, s1_w2_nxt;
  logic [31:0]          s1_z1_nxt, s1_z2_nxt;
  logic                 f1, f2;

  always_comb begin
    s1_w1_nxt = DW'(s0_p1_r >>> (20 - FB));
    s1_w2_nxt = DW'(s0_p2_r >>> (20 - FB));
    f1 = s0_z1_r[31] ^ s0_z1_r[30];
    f2 = s0_z2_r[31] ^ s0_z2_r[30];
    s1_z1_nxt = s0_z1_r;
    s1_z2_nxt = s0_z2_r;
    if (f1) begin
      s1_w1_nxt = -s1_w1_nxt;
      s1_z1_nxt = s0_z1_r ^ 32'h80000000;
    end
    if (f2) begin
      s1_w2_nxt = -s1_w2_nxt;
      s1_z2_nxt = s0_z2_r ^ 32'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w1_r <= s1_w1_nxt;
      s1_w2_r <= s1_w2_nxt;
      s1_z1_r <= {s1_z1_nxt[31], s1_z1_nxt};
      s1_z2_r <= {s1_z2_nxt[31], s1_z2_nxt};
    end
  end

  assign r_vld[0] = s1_vld_r;
  assign r_w1[0]  = s1_w1_r;
  assign r_y1[0]  = '0;
  assign r_z1[0]  = s1_z1_r;
  assign r_w2[0]  = s1_w2_r;
  assign r_y2[0]  = '0;
  assign r_z2[0]  = s1_z2_r;

  // rotation chain
  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    pva_rot_stage #(.STEP(i), .DW(DW)) u_rot (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .vld_i (r_vld[i]),
      .w1_i  (r_w1[i]),
      .y1_i  (r_y1[i]),
      .z1_i  (r_z1[i]),
      .w2_i  (r_w2[i]),
      .y2_i  (r_y2[i]),
      .z2_i  (r_z2[i]),
      .vld_o (r_vld[i+1]),
      .w1_o  (r_w1[i+1]),
      .y1_o  (r_y1[i+1]),
      .z1_o  (r_z1[i+1]),
      .w2_o  (r_w2[i+1]),
      .y2_o  (r_y2[i+1]),
      .z2_o  (r_z2[i+1])
    );
  end

  // stage 2: sum parts, fold to upper half, flag zero
  logic                 s2_vld_r, s2_zero_r;
  logic signed [DW-1:0] s2_u_r, s2_x_r;
  logic [31:0]          s2_z_r;
  logic signed [DW-1:0] su, sx;

  assign su = r_w1[ROTATION_STEPS] + r_w2[ROTATION_STEPS];
  assign sx = r_y1[ROTATION_STEPS] + r_y2[ROTATION_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= r_vld[ROTATION_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_zero_r <= (su == '0) && (sx == '0);
      if (su[DW-1]) begin
        s2_u_r <= -su;
        s2_x_r <= -sx;
        s2_z_r <= 32'h80000000;
      end else begin
        s2_u_r <= su;
        s2_x_r <= sx;
        s2_z_r <= '0;
      end
    end
  end

  // vectoring chain
  logic                 v_vld  [ROTATION_STEPS+1];
  logic                 v_zero [ROTATION_STEPS+1];
  logic signed [DW-1:0] v_u    [ROTATION_STEPS+1];
  logic signed [DW-1:0] v_x    [ROTATION_STEPS+1];
  logic [31:0]          v_z    [ROTATION_STEPS+1];

  assign v_vld[0]  = s2_vld_r;
  assign v_zero[0] = s2_zero_r;
  assign v_u[0]    = s2_u_r;
  assign v_x[0]    = s2_x_r;
  assign v_z[0]    = s2_z_r;

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_vec
    pva_vec_stage #(.STEP(i), .DW(DW)) u_vec (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (v_vld[i]),
      .zero_i (v_zero[i]),
      .u_i    (v_u[i]),
      .x_i    (v_x[i]),
      .z_i    (v_z[i]),
      .vld_o  (v_vld[i+1]),
      .zero_o (v_zero[i+1]),
      .u_o    (v_u[i+1]),
      .x_o    (v_x[i+1]),
      .z_o    (v_z[i+1])
    );
  end

  // stage 3: gain multiply on magnitude, round heading
  logic                 s3_vld_r, s3_zero_r;
  logic signed [MW-1:0] s3_m_r;
  logic [ANGLE_BITS-1:0] s3_h_r;
  logic signed [DW-1:0] uc;
  logic [31:0]          zr;

  assign uc = v_u[ROTATION_STEPS][DW-1] ? '0 : v_u[ROTATION_STEPS];
  assign zr = (SH > 0) ? v_z[ROTATION_STEPS] + (32'd1 << (SH > 0 ? SH - 1 : 0))
                       : v_z[ROTATION_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= v_vld[ROTATION_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_zero_r <= v_zero[ROTATION_STEPS];
      s3_m_r    <= MW'(uc * GAIN);
      s3_h_r    <= zr[31 -: ANGLE_BITS];
    end
  end

  // stage 4: round, saturate, output register
  logic                  out_vld_r;
  pva_pkg::pva_out_t     out_r;
  logic signed [MW-1:0]  mr;
  logic [MW-1:0]         mq;
  logic [LENGTH_BITS:0]  mag;
  logic [ANGLE_BITS-1:0] hd;

  always_comb begin
    mr = s3_m_r + (MW'(1) <<< (19 + FB));
    mq = mr >>> (20 + FB);
    if (mq > MW'(1) << LENGTH_BITS) begin
      mag = (LENGTH_BITS+1)'(1) << LENGTH_BITS;
    end else begin
      mag = mq[LENGTH_BITS:0];
    end
    hd = s3_h_r;
    if (s3_zero_r) begin
      mag = '0;
      hd  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.sum_heading <= pva_pkg::HEAD_W'(hd);
      out_r.sum_length  <= (pva_pkg::LEN_W+1)'(mag);
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the polar vector adder against a cordic sum predictor. Requests
// come from a queue filled up front, with random gaps and a long result
// hold-off. Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pva_pkg::pva_in_t   in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pva_pkg::pva_out_t  out_data;

  pva_pkg::pva_in_t  pending_reqs[$];
  pva_pkg::pva_out_t expected_sums[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  int       cycle_no = 0;
  int       hold_left = 0;
  bit       stim_done = 0;

  polar_vector_add uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // arithmetic shift right toward minus infinity
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  // polar to upward and rightward parts via rotation cordic
  function automatic void rotate_to_xy(logic [15:0] hd, logic signed [15:0] len,
                                       output longint up, output longint rt);
    longint unsigned z32;
    longint w, y, z, dw, dy;
    logic [1:0] q;
    z32 = longint'(hd) << 16;
    w = shr(longint'(len) * pva_pkg::GAIN_Q20, 20 - pva_pkg::FRAC_BITS);
    y = 0;
    q = z32[31:30];
    if (q == 2'd1 || q == 2'd2) begin
      w = -w;
      z32 = (z32 - 64'h8000_0000) & 64'hFFFF_FFFF;
    end
    z = (z32 >= 64'h8000_0000) ? longint'(z32) - (64'sd1 <<< 32) : longint'(z32);
    for (int i = 0; i < 16; i++) begin
      dw = shr(y, i);
      dy = shr(w, i);
      if (z >= 0) begin
        w -= dw; y += dy; z -= longint'(pva_pkg::atan_turn(5'(i)));
      end else begin
        w += dw; y -= dy; z += longint'(pva_pkg::atan_turn(5'(i)));
      end
    end
    up = w;
    rt = y;
  endfunction

  // expected heading and magnitude of the vector sum
  function automatic pva_pkg::pva_out_t predict_sum(pva_pkg::pva_in_t r);
    longint u1, x1, u2, x2, su, sx, z, du, dx, mag;
    logic [31:0] z32;
    pva_pkg::pva_out_t o;
    rotate_to_xy(r.first_heading, r.first_length, u1, x1);
    rotate_to_xy(r.second_heading, r.second_length, u2, x2);
    su = u1 + u2;
    sx = x1 + x2;
    o = '0;
    if (su == 0 && sx == 0) return o;
    z = 0;
    if (su < 0) begin
      su = -su; sx = -sx; z = 64'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      du = shr(sx, i);
      dx = shr(su, i);
      if (sx > 0) begin
        su += du; sx -= dx; z += longint'(pva_pkg::atan_turn(5'(i)));
      end else begin
        su -= du; sx += dx; z -= longint'(pva_pkg::atan_turn(5'(i)));
      end
    end
    z32 = z[31:0] + 32'h8000;
    o.sum_heading = z32[31:16];
    if (su < 0) su = 0;
    mag = shr(su * pva_pkg::GAIN_Q20 + (64'sd1 <<< (19 + pva_pkg::FRAC_BITS)),
              20 + pva_pkg::FRAC_BITS);
    if (mag > 65536) mag = 65536;
    o.sum_length = mag[16:0];
    return o;
  endfunction

  function automatic pva_pkg::pva_in_t rand_req();
    pva_pkg::pva_in_t r;
    r.first_heading  = 16'($urandom);
    r.second_heading = 16'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        r.first_length  = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        r.second_length = 16'($urandom);
      end
      1: begin
        // opposing vectors of equal length nearly cancel
        r.first_length  = 16'($urandom);
        r.second_length = r.first_length;
        r.second_heading = r.first_heading + 16'h8000;
      end
      default: begin
        r.first_length  = 16'($urandom);
        r.second_length = 16'($urandom);
      end
    endcase
    return r;
  endfunction

  // directed corners then random pairs
  initial begin
    pva_pkg::pva_in_t r;
    logic [15:0] hd_set[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2000};
    for (int i = 0; i < 6; i++) begin
      r.first_heading  = hd_set[i];
      r.first_length   = (i % 2) ? 16'sh8000 : 16'sh7fff;
      r.second_heading = hd_set[5 - i];
      r.second_length  = (i % 3) ? 16'sh7fff : 16'sh8001;
      pending_reqs.push_back(r);
    end
    pending_reqs.push_back('0);
    pending_reqs.push_back('{16'h1234, 16'sd1000, 16'h9234, 16'sd1000});
    pending_reqs.push_back('{16'h0000, 16'sd500, 16'h0000, -16'sd500});
    pending_reqs.push_back('{16'h0000, 16'sh7fff, 16'h0000, 16'sh7fff});
    pending_reqs.push_back('{16'h8000, 16'sh8000, 16'h8000, 16'sh8000});
    pending_reqs.push_back('{16'hffff, 16'sd1, 16'h0000, 16'sd0});
    pending_reqs.push_back('{16'h0000, -16'sd1, 16'h7fff, 16'sd0});
    pending_reqs.push_back('{16'h5555, 16'sd3, 16'haaaa, 16'sd3});
    pending_reqs.push_back('{16'hffff, 16'shffff, 16'hffff, 16'shffff});
    pending_reqs.push_back('{16'h0000, 16'sd0, 16'hc000, 16'sd12345});
    for (int i = 0; i < 1300; i++) pending_reqs.push_back(rand_req());
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // request driver
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_sums.push_back(predict_sum(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 &&
            (cycle_no > 300 && cycle_no < 700 || $urandom_range(0, 99) >= 14)) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (pending_reqs.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // result stall, with one long hold-off
  always @(posedge clk) begin
    if (cycle_no == 900) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (cycle_no > 300 && cycle_no < 700) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 14);
    end
  end

  // result monitor
  always @(posedge clk) begin
    pva_pkg::pva_out_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result heading %h length %h", $time,
                 out_data.sum_heading, out_data.sum_length);
        err_count++;
      end else begin
        exp_o = expected_sums.pop_front();
        if (exp_o.sum_heading !== out_data.sum_heading) begin
          $display("%0t: sum_heading expected %h actual %h", $time,
                   exp_o.sum_heading, out_data.sum_heading);
          err_count++;
        end
        if (exp_o.sum_length !== out_data.sum_length) begin
          $display("%0t: sum_length expected %h actual %h", $time,
                   exp_o.sum_length, out_data.sum_length);
          err_count++;
        end
      end
    end
    // cycles with no request or result accepted
    if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // end of run and watchdog
  initial begin
    while (!(stim_done && !in_valid && expected_sums.size() == 0) &&
           idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (err_count == 0 && expected_sums.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
    end
    $finish;
  end
endmodule
